/* rtl/core/abkf_pkg.sv */
// ----------------------------------------------------------------------------
// abkf_pkg
// Shared types, constants and arithmetic helpers of the angle/bias filter.
// ----------------------------------------------------------------------------
package abkf_pkg;

   localparam int AXES      = 2;
   localparam int AXIS_W    = (AXES > 1) ? $clog2(AXES) : 1;
   localparam int DATA_W    = 32;
   localparam int CSR_W     = 31;
   localparam int TS_W      = 25;
   localparam int DIV_STEPS = 57;

   localparam logic [31:0] ONE_Q24 = 32'sd16777216;

   // Configuration register indexes.
   localparam logic [1:0] CSR_MEAS_NOISE  = 2'd0;
   localparam logic [1:0] CSR_ANGLE_NOISE = 2'd1;
   localparam logic [1:0] CSR_BIAS_NOISE  = 2'd2;

   // Multiplier operand select codes.
   typedef enum logic [3:0] {
      MUL_TS_RATE  = 4'd0,
      MUL_TS_BA    = 4'd1,
      MUL_TS_AB    = 4'd2,
      MUL_TS_TS    = 4'd3,
      MUL_TT_BB    = 4'd4,
      MUL_TS_BB    = 4'd5,
      MUL_K0_Y     = 4'd6,
      MUL_K1_Y     = 4'd7,
      MUL_K0_PAA   = 4'd8,
      MUL_K0_PAB   = 4'd9,
      MUL_K1_PAA   = 4'd10,
      MUL_K1_PAB   = 4'd11
   } mul_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        load;
      logic        mul_go;
      mul_sel_type mul_sel;
      logic        pre_calc;
      logic        div_start;
      logic        div_second;
      logic        write_back;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic reject;
      logic div_done;
   } sts_type;

   // Saturate a 64-bit signed value to 32 bits.
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647)
         return 32'sh7fffffff;
      else if (v < -64'sd2147483648)
         return 32'sh80000000;
      else
         return v[31:0];
   endfunction

   // Q8.24 product rounding: add half, floor shift.
   function automatic logic signed [39:0] qround(input logic signed [63:0] p);
      logic signed [63:0] t;
      t = p + 64'sd8388608;
      return t[63:24];
   endfunction

endpackage

/* rtl/core/angle_bias_kalman_filter.sv */
// ----------------------------------------------------------------------------
// angle_bias_kalman_filter
// Two-state angle and gyro-bias Kalman filter over several axes.
//
//   channel | direction | ports
//   req     | in        | req_valid, req_stall, axis, rate, angle, period
//   rsp     | out       | rsp_valid, rsp_stall, axis, angle, bias, accepted
//   csr     | in        | csr_write, csr_index, csr_data
//
// An applied item runs six multiplies, a predict step, two 57-step
// restoring divides, six more multiplies and a write-back; a rejected item
// goes from the check straight to write-back. No new item is taken until the
// sequencer is back in idle. Synchronous reset sets the filter state to its
// initial estimate. A result still waiting in its register holds off the
// next item.
// ----------------------------------------------------------------------------
module angle_bias_kalman_filter (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write,
   input  logic [1:0]                  csr_index,
   input  logic [abkf_pkg::CSR_W-1:0]  csr_data,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_axis,
   input  logic signed [31:0]          req_gyro_rate,
   input  logic signed [31:0]          req_meas_angle,
   input  logic [abkf_pkg::TS_W-1:0]   req_step_time,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_axis_out,
   output logic signed [31:0]          rsp_angle_out,
   output logic signed [31:0]          rsp_bias_out,
   output logic                        rsp_accepted
);

   abkf_pkg::cmd_type cmd;
   abkf_pkg::sts_type sts;

   // Sequencer.
   abkf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Arithmetic and state.
   abkf_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_axis       (req_axis),
      .req_gyro_rate  (req_gyro_rate),
      .req_meas_angle (req_meas_angle),
      .req_step_time  (req_step_time),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_axis_out   (rsp_axis_out),
      .rsp_angle_out  (rsp_angle_out),
      .rsp_bias_out   (rsp_bias_out),
      .rsp_accepted   (rsp_accepted)
   );

endmodule

/* rtl/core/abkf_ctrl.sv */
// ----------------------------------------------------------------------------
// abkf_ctrl
// Sequencer of the filter step: multiplies, two divides and write-back.
// ----------------------------------------------------------------------------
module abkf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  abkf_pkg::sts_type sts,
   output abkf_pkg::cmd_type cmd
);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b00000001,
      ST_CHECK = 8'b00000010,
      ST_MUL1  = 8'b00000100,
      ST_PRE   = 8'b00001000,
      ST_DIV   = 8'b00010000,
      ST_MUL2  = 8'b00100000,
      ST_WB    = 8'b01000000,
      ST_OUT   = 8'b10000000
   } state_type;

   state_type   state_ff, state_in;
   logic [3:0]  step_ff, step_in;
   logic        second_ff, second_in;
   logic        out_busy;

   // The result register frees once its item is taken.
   assign out_busy  = rsp_valid && rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || out_busy;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      second_in = second_ff;
      cmd       = '0;
      cmd.mul_sel = abkf_pkg::MUL_TS_RATE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !out_busy) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            step_in = '0;
            if (sts.reject) state_in = ST_WB;
            else state_in = ST_MUL1;
         end
         ST_MUL1: begin
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = abkf_pkg::mul_sel_type'(step_ff);
            step_in     = step_ff + 4'd1;
            if (step_ff == 4'(abkf_pkg::MUL_TS_BB)) state_in = ST_PRE;
         end
         ST_PRE: begin
            cmd.pre_calc  = 1'b1;
            state_in      = ST_DIV;
            second_in     = 1'b0;
            cmd.div_start = 1'b1;
         end
         ST_DIV: begin
            cmd.div_second = second_ff;
            if (sts.div_done) begin
               if (second_ff) begin
                  state_in = ST_MUL2;
                  step_in  = 4'(abkf_pkg::MUL_K0_Y);
               end else begin
                  second_in     = 1'b1;
                  cmd.div_start = 1'b1;
               end
            end
         end
         ST_MUL2: begin
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = abkf_pkg::mul_sel_type'(step_ff);
            step_in     = step_ff + 4'd1;
            if (step_ff == 4'(abkf_pkg::MUL_K1_PAB)) state_in = ST_WB;
         end
         ST_WB: begin
            cmd.write_back = 1'b1;
            state_in       = ST_OUT;
         end
         ST_OUT: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Result valid is set on entry to the output state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         step_ff   <= '0;
         second_ff <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff  <= state_in;
         step_ff   <= step_in;
         second_ff <= second_in;
         if (state_ff == ST_WB) rsp_valid <= 1'b1;
         else if (!rsp_stall) rsp_valid <= 1'b0;
      end
   end

endmodule

/* rtl/core/abkf_datapath.sv */
// ----------------------------------------------------------------------------
// abkf_datapath
// Per-axis state, shared multiplier, restoring divider and result register.
// ----------------------------------------------------------------------------
module abkf_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write,
   input  logic [1:0]                   csr_index,
   input  logic [abkf_pkg::CSR_W-1:0]   csr_data,
   input  logic                         req_axis,
   input  logic signed [31:0]           req_gyro_rate,
   input  logic signed [31:0]           req_meas_angle,
   input  logic [abkf_pkg::TS_W-1:0]    req_step_time,
   input  abkf_pkg::cmd_type            cmd,
   output abkf_pkg::sts_type            sts,
   output logic                         rsp_axis_out,
   output logic signed [31:0]           rsp_angle_out,
   output logic signed [31:0]           rsp_bias_out,
   output logic                         rsp_accepted
);

   localparam int AX = abkf_pkg::AXES;

   logic [abkf_pkg::CSR_W-1:0] meas_noise_ff, angle_noise_ff, bias_noise_ff;
   logic signed [31:0] angle_ff [AX];
   logic signed [31:0] bias_ff  [AX];
   logic signed [31:0] caa_ff [AX];
   logic signed [31:0] cab_ff [AX];
   logic signed [31:0] cba_ff [AX];
   logic signed [31:0] cbb_ff [AX];

   logic               axis_ff, valid_ax_ff, reject_ff;
   logic [abkf_pkg::AXIS_W-1:0] ax_idx;
   logic signed [31:0] gyro_ff, meas_ff, a_ff, b_ff, rate_ff;
   logic signed [31:0] aa_ff, ab_ff, ba_ff, bb_ff;
   logic signed [31:0] ts_ff;
   logic signed [39:0] m_ff [12];
   logic signed [31:0] apred_ff, paa_ff, pab_ff, pba_ff, pbb_ff, y_ff, s_ff;
   logic signed [31:0] k0_ff, k1_ff;

   // Divider registers.
   logic [63:0]  dquo_ff;
   logic [95:0]  drem_ff;
   logic [31:0]  dden_ff;
   logic         dneg_ff, dzero_ff, dbusy_ff;
   logic [5:0]   dcnt_ff;
   logic [32:0]  dtrial;
   logic signed [64:0] dq_signed;

   logic signed [31:0] opa, opb;
   logic signed [63:0] prod;

   assign ax_idx = abkf_pkg::AXIS_W'(axis_ff);
   assign sts.reject = reject_ff;
   assign sts.div_done = dbusy_ff && (dcnt_ff == 6'd0);

   // Multiplier operand selection.
   always_comb begin
      opa = ts_ff;
      opb = rate_ff;
      case (cmd.mul_sel)
         abkf_pkg::MUL_TS_RATE: begin opa = ts_ff; opb = rate_ff; end
         abkf_pkg::MUL_TS_BA:   begin opa = ts_ff; opb = ba_ff;   end
         abkf_pkg::MUL_TS_AB:   begin opa = ts_ff; opb = ab_ff;   end
         abkf_pkg::MUL_TS_TS:   begin opa = ts_ff; opb = ts_ff;   end
         abkf_pkg::MUL_TT_BB:   begin
            opa = m_ff[abkf_pkg::MUL_TS_TS][31:0];
            opb = bb_ff;
         end
         abkf_pkg::MUL_TS_BB:   begin opa = ts_ff; opb = bb_ff;   end
         abkf_pkg::MUL_K0_Y:    begin opa = k0_ff; opb = y_ff;    end
         abkf_pkg::MUL_K1_Y:    begin opa = k1_ff; opb = y_ff;    end
         abkf_pkg::MUL_K0_PAA:  begin opa = k0_ff; opb = paa_ff;  end
         abkf_pkg::MUL_K0_PAB:  begin opa = k0_ff; opb = pab_ff;  end
         abkf_pkg::MUL_K1_PAA:  begin opa = k1_ff; opb = paa_ff;  end
         abkf_pkg::MUL_K1_PAB:  begin opa = k1_ff; opb = pab_ff;  end
         default:               begin opa = ts_ff; opb = rate_ff; end
      endcase
   end
   assign prod = opa * opb;

   // One restoring divide step on the magnitude.
   assign dtrial = {1'b0, drem_ff[95:64]} - {1'b0, dden_ff};
   assign dq_signed = dneg_ff ? -$signed({1'b0, dquo_ff}) : $signed({1'b0, dquo_ff});

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         meas_noise_ff  <= 31'd8388608;
         angle_noise_ff <= 31'd16777;
         bias_noise_ff  <= 31'd50332;
      end else if (csr_write) begin
         case (csr_index)
            abkf_pkg::CSR_MEAS_NOISE:  meas_noise_ff  <= csr_data;
            abkf_pkg::CSR_ANGLE_NOISE: angle_noise_ff <= csr_data;
            abkf_pkg::CSR_BIAS_NOISE:  bias_noise_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // Working registers of one step.
   always_ff @(posedge clock) begin
      logic signed [63:0] num;
      logic signed [31:0] den;
      if (cmd.load) begin
         axis_ff     <= req_axis;
         valid_ax_ff <= (32'(req_axis) < 32'(AX));
         gyro_ff     <= req_gyro_rate;
         meas_ff     <= req_meas_angle;
         ts_ff       <= {7'd0, req_step_time};
         reject_ff   <= (req_step_time == '0) ||
                        ({7'd0, req_step_time} > abkf_pkg::ONE_Q24) ||
                        !(32'(req_axis) < 32'(AX));
         a_ff  <= angle_ff[abkf_pkg::AXIS_W'(req_axis)];
         b_ff  <= bias_ff[abkf_pkg::AXIS_W'(req_axis)];
         aa_ff <= caa_ff[abkf_pkg::AXIS_W'(req_axis)];
         ab_ff <= cab_ff[abkf_pkg::AXIS_W'(req_axis)];
         ba_ff <= cba_ff[abkf_pkg::AXIS_W'(req_axis)];
         bb_ff <= cbb_ff[abkf_pkg::AXIS_W'(req_axis)];
         rate_ff <= abkf_pkg::sat32(64'(req_gyro_rate) -
                    64'(bias_ff[abkf_pkg::AXIS_W'(req_axis)]));
      end
      if (cmd.mul_go) begin
         m_ff[cmd.mul_sel] <= abkf_pkg::qround(prod);
      end
      // Predicted values from the first product group.
      if (cmd.pre_calc) begin
         apred_ff <= abkf_pkg::sat32(64'(a_ff) + 64'(m_ff[abkf_pkg::MUL_TS_RATE]));
         paa_ff <= abkf_pkg::sat32(64'(aa_ff) - 64'(m_ff[abkf_pkg::MUL_TS_BA])
                   - 64'(m_ff[abkf_pkg::MUL_TS_AB]) + 64'(m_ff[abkf_pkg::MUL_TT_BB])
                   + 64'(angle_noise_ff));
         pab_ff <= abkf_pkg::sat32(64'(ab_ff) - 64'(m_ff[abkf_pkg::MUL_TS_BB]));
         pba_ff <= abkf_pkg::sat32(64'(ba_ff) - 64'(m_ff[abkf_pkg::MUL_TS_BB]));
         pbb_ff <= abkf_pkg::sat32(64'(bb_ff) + 64'(bias_noise_ff));
      end
      // Divider: start, then one quotient bit per cycle.
      if (reset) begin
         dbusy_ff <= 1'b0;
      end else if (cmd.div_start) begin
         if (cmd.pre_calc) begin
            num = 64'(abkf_pkg::sat32(64'(aa_ff) - 64'(m_ff[abkf_pkg::MUL_TS_BA])
                  - 64'(m_ff[abkf_pkg::MUL_TS_AB]) + 64'(m_ff[abkf_pkg::MUL_TT_BB])
                  + 64'(angle_noise_ff)));
            den = abkf_pkg::sat32(num + 64'(meas_noise_ff));
            s_ff <= den;
            y_ff <= abkf_pkg::sat32(64'(meas_ff) - 64'(abkf_pkg::sat32(64'(a_ff)
                    + 64'(m_ff[abkf_pkg::MUL_TS_RATE]))));
         end else begin
            num = 64'(pba_ff);
            den = s_ff;
         end
         num = num <<< 24;
         dneg_ff  <= num[63] ^ den[31];
         dzero_ff <= (den == 32'sd0);
         dden_ff  <= den[31] ? 32'(-$signed({den[31], den})) : den;
         // The magnitude stays below 2^56, so it sits eight bits up and the
         // step count covers all of its bits.
         drem_ff  <= {32'd0, (num[63] ? -num : num) << 8};
         dquo_ff  <= '0;
         dcnt_ff  <= 6'(abkf_pkg::DIV_STEPS);
         dbusy_ff <= 1'b1;
      end else if (dbusy_ff && dcnt_ff != 6'd0) begin
         if (!dtrial[32]) begin
            drem_ff <= {dtrial[30:0], drem_ff[63:0], 1'b0};
            dquo_ff <= {dquo_ff[62:0], 1'b1};
         end else begin
            drem_ff <= {drem_ff[94:0], 1'b0};
            dquo_ff <= {dquo_ff[62:0], 1'b0};
         end
         dcnt_ff <= dcnt_ff - 6'd1;
      end else if (sts.div_done) begin
         dbusy_ff <= 1'b0;
      end
      // A finished divide hands its quotient to the gain it belongs to.
      if (sts.div_done) begin
         if (cmd.div_second) k1_ff <= dzero_ff ? 32'sd0 : abkf_pkg::sat32(dq_signed[63:0]);
         else k0_ff <= dzero_ff ? 32'sd0 : abkf_pkg::sat32(dq_signed[63:0]);
      end
   end

   // State array and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AX; i++) begin
            angle_ff[i] <= '0;
            bias_ff[i]  <= '0;
            caa_ff[i]   <= abkf_pkg::ONE_Q24;
            cab_ff[i]   <= '0;
            cba_ff[i]   <= '0;
            cbb_ff[i]   <= abkf_pkg::ONE_Q24;
         end
      end else if (cmd.write_back) begin
         rsp_axis_out <= axis_ff;
         if (!valid_ax_ff) begin
            rsp_angle_out <= '0;
            rsp_bias_out  <= '0;
            rsp_accepted  <= 1'b0;
         end else if (reject_ff) begin
            rsp_angle_out <= a_ff;
            rsp_bias_out  <= b_ff;
            rsp_accepted  <= 1'b0;
         end else begin
            angle_ff[ax_idx] <= abkf_pkg::sat32(64'(apred_ff) + 64'(m_ff[abkf_pkg::MUL_K0_Y]));
            bias_ff[ax_idx]  <= abkf_pkg::sat32(64'(b_ff) + 64'(m_ff[abkf_pkg::MUL_K1_Y]));
            caa_ff[ax_idx] <= abkf_pkg::sat32(64'(paa_ff) - 64'(m_ff[abkf_pkg::MUL_K0_PAA]));
            cab_ff[ax_idx] <= abkf_pkg::sat32(64'(pab_ff) - 64'(m_ff[abkf_pkg::MUL_K0_PAB]));
            cba_ff[ax_idx] <= abkf_pkg::sat32(64'(pba_ff) - 64'(m_ff[abkf_pkg::MUL_K1_PAA]));
            cbb_ff[ax_idx] <= abkf_pkg::sat32(64'(pbb_ff) - 64'(m_ff[abkf_pkg::MUL_K1_PAB]));
            rsp_angle_out <= abkf_pkg::sat32(64'(apred_ff) + 64'(m_ff[abkf_pkg::MUL_K0_Y]));
            rsp_bias_out  <= abkf_pkg::sat32(64'(b_ff) + 64'(m_ff[abkf_pkg::MUL_K1_Y]));
            rsp_accepted  <= 1'b1;
         end
      end
   end

endmodule
